// ----- rtl/vsr_pkg.sv -----
// Shared types and constants of the voxel shape rasterizer.
package vsr_pkg;

	// Command kinds carried in s_tuser
	localparam logic [3:0] KIND_PUT_VOXEL     = 4'd0;
	localparam logic [3:0] KIND_CUT_VOXEL     = 4'd1;
	localparam logic [3:0] KIND_PUT_BOX       = 4'd2;
	localparam logic [3:0] KIND_CUT_BOX       = 4'd3;
	localparam logic [3:0] KIND_PUT_SPHERE    = 4'd4;
	localparam logic [3:0] KIND_CUT_SPHERE    = 4'd5;
	localparam logic [3:0] KIND_PUT_ELLIPSOID = 4'd6;
	localparam logic [3:0] KIND_CUT_ELLIPSOID = 4'd7;

	// Configuration register indexes
	localparam logic [2:0] CFG_BOX_ROWS    = 3'd0;
	localparam logic [2:0] CFG_BOX_COLS    = 3'd1;
	localparam logic [2:0] CFG_BOX_PLANES  = 3'd2;
	localparam logic [2:0] CFG_SPHERE_R    = 3'd3;
	localparam logic [2:0] CFG_ELL_ROW_R   = 3'd4;
	localparam logic [2:0] CFG_ELL_COL_R   = 3'd5;
	localparam logic [2:0] CFG_ELL_PLANE_R = 3'd6;
	localparam logic [2:0] CFG_DRAW_COLOR  = 3'd7;

	localparam logic [31:0] DRAW_COLOR_RST = 32'd255;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP_A,
		ST_SETUP_B,
		ST_SETUP_C,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_RESP
	} vsr_state_t;

	typedef struct packed {
		logic capture;
		logic clr_step;
		logic setup_a;
		logic setup_b;
		logic setup_c;
		logic scan_en;
		logic read_en;
		logic out_load;
	} vsr_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic skip;
		logic scan_last;
		logic pipe_busy;
		logic out_full;
	} vsr_stat_t;

endpackage

// ----- rtl/vsr_ctrl.sv -----
// Controller state machine of the voxel shape rasterizer.
module vsr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vsr_pkg::vsr_stat_t  stat,
	output vsr_pkg::vsr_cmd_t   cmd
);

	vsr_pkg::vsr_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vsr_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			vsr_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_nx = vsr_pkg::ST_IDLE;
			end
			vsr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = vsr_pkg::ST_SETUP_A;
				end
			end
			vsr_pkg::ST_SETUP_A: begin
				cmd.setup_a = 1'b1;
				state_nx = stat.skip ? vsr_pkg::ST_READ : vsr_pkg::ST_SETUP_B;
			end
			vsr_pkg::ST_SETUP_B: begin
				cmd.setup_b = 1'b1;
				state_nx    = vsr_pkg::ST_SETUP_C;
			end
			vsr_pkg::ST_SETUP_C: begin
				cmd.setup_c = 1'b1;
				state_nx    = vsr_pkg::ST_SCAN;
			end
			vsr_pkg::ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.scan_last) state_nx = vsr_pkg::ST_DRAIN;
			end
			vsr_pkg::ST_DRAIN: begin
				// wait for the last writes to land
				if (!stat.pipe_busy) state_nx = vsr_pkg::ST_READ;
			end
			vsr_pkg::ST_READ: begin
				cmd.read_en = 1'b1;
				state_nx    = vsr_pkg::ST_RESP;
			end
			vsr_pkg::ST_RESP: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_nx     = vsr_pkg::ST_IDLE;
				end
			end
			default: state_nx = vsr_pkg::ST_CLEAR;
		endcase
	end

endmodule

// ----- rtl/vsr_dp.sv -----
// Datapath of the voxel shape rasterizer: config, scan counters, test pipeline, grid memory.
module vsr_dp #(
	parameter int GRID_ROWS   = 32,
	parameter int GRID_COLS   = 32,
	parameter int GRID_PLANES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_data,
	input  logic [3:0]         in_kind,
	input  logic [4:0]         in_row,
	input  logic [4:0]         in_col,
	input  logic [4:0]         in_plane,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [55:0]        out_data,
	input  vsr_pkg::vsr_cmd_t  cmd,
	output vsr_pkg::vsr_stat_t stat
);

	localparam int DEPTH = GRID_ROWS * GRID_COLS * GRID_PLANES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [8:0] ROWS_L   = 9'(GRID_ROWS);
	localparam logic [8:0] COLS_L   = 9'(GRID_COLS);
	localparam logic [8:0] PLANES_L = 9'(GRID_PLANES);

	// configuration registers
	logic [5:0]  box_rows_q, box_cols_q, box_planes_q;
	logic [4:0]  sph_r_q, ell_a_q, ell_b_q, ell_c_q;
	logic [31:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_rows_q   <= '0;
			box_cols_q   <= '0;
			box_planes_q <= '0;
			sph_r_q      <= '0;
			ell_a_q      <= '0;
			ell_b_q      <= '0;
			ell_c_q      <= '0;
			color_q      <= vsr_pkg::DRAW_COLOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				vsr_pkg::CFG_BOX_ROWS:    box_rows_q   <= cfg_data[5:0];
				vsr_pkg::CFG_BOX_COLS:    box_cols_q   <= cfg_data[5:0];
				vsr_pkg::CFG_BOX_PLANES:  box_planes_q <= cfg_data[5:0];
				vsr_pkg::CFG_SPHERE_R:    sph_r_q      <= cfg_data[4:0];
				vsr_pkg::CFG_ELL_ROW_R:   ell_a_q      <= cfg_data[4:0];
				vsr_pkg::CFG_ELL_COL_R:   ell_b_q      <= cfg_data[4:0];
				vsr_pkg::CFG_ELL_PLANE_R: ell_c_q      <= cfg_data[4:0];
				vsr_pkg::CFG_DRAW_COLOR:  color_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item
	logic [3:0] kind_q;
	logic [4:0] ar_q, ac_q, ap_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			ar_q   <= in_row;
			ac_q   <= in_col;
			ap_q   <= in_plane;
		end
	end

	// shape decode
	logic is_vox, is_box, is_sph, is_ell, put;
	logic za, zb, zc;
	assign is_vox = (kind_q == vsr_pkg::KIND_PUT_VOXEL) || (kind_q == vsr_pkg::KIND_CUT_VOXEL);
	assign is_box = (kind_q == vsr_pkg::KIND_PUT_BOX) || (kind_q == vsr_pkg::KIND_CUT_BOX);
	assign is_sph = (kind_q == vsr_pkg::KIND_PUT_SPHERE) || (kind_q == vsr_pkg::KIND_CUT_SPHERE);
	assign is_ell = (kind_q == vsr_pkg::KIND_PUT_ELLIPSOID) ||
	                (kind_q == vsr_pkg::KIND_CUT_ELLIPSOID);
	assign put = ~kind_q[0];
	assign za  = (ell_a_q == '0);
	assign zb  = (ell_b_q == '0);
	assign zc  = (ell_c_q == '0);

	assign stat.skip = !(is_vox || is_box || is_sph || is_ell) ||
	                   (is_box && (box_rows_q == '0 || box_cols_q == '0 ||
	                               box_planes_q == '0)) ||
	                   (is_ell && ((za && zb) || (za && zc) || (zb && zc)));

	// scan bounds per axis
	function automatic logic [6:0] neg7(input logic [4:0] v);
		neg7 = 7'(-$signed({2'b00, v}));
	endfunction

	logic [6:0] lo_i, hi_i, lo_j, hi_j, lo_k, hi_k;
	always_comb begin
		lo_i = '0; hi_i = '0; lo_j = '0; hi_j = '0; lo_k = '0; hi_k = '0;
		if (is_box) begin
			hi_i = {1'b0, box_rows_q} - 7'd1;
			hi_j = {1'b0, box_cols_q} - 7'd1;
			hi_k = {1'b0, box_planes_q} - 7'd1;
		end else if (is_sph) begin
			lo_i = neg7(sph_r_q); hi_i = {2'b00, sph_r_q};
			lo_j = neg7(sph_r_q); hi_j = {2'b00, sph_r_q};
			lo_k = neg7(sph_r_q); hi_k = {2'b00, sph_r_q};
		end else if (is_ell) begin
			lo_i = neg7(ell_a_q); hi_i = {2'b00, ell_a_q};
			lo_j = neg7(ell_b_q); hi_j = {2'b00, ell_b_q};
			lo_k = neg7(ell_c_q); hi_k = {2'b00, ell_c_q};
		end
	end

	// a flat axis scans only the anchor slice and weighs as radius one
	logic [4:0] ea, eb, ec;
	assign ea = za ? 5'd1 : ell_a_q;
	assign eb = zb ? 5'd1 : ell_b_q;
	assign ec = zc ? 5'd1 : ell_c_q;

	logic [6:0]  lo_i_q, hi_i_q, lo_j_q, hi_j_q, lo_k_q, hi_k_q;
	logic        test_q;
	logic [9:0]  a2_q, b2_q, c2_q;
	logic [19:0] cp_q, cq_q, cs_q;
	logic [31:0] lim_q;

	always_ff @(posedge clk) begin
		if (cmd.setup_a) begin
			lo_i_q <= lo_i; hi_i_q <= hi_i;
			lo_j_q <= lo_j; hi_j_q <= hi_j;
			lo_k_q <= lo_k; hi_k_q <= hi_k;
			test_q <= is_sph || is_ell;
			a2_q   <= is_sph ? {5'd0, sph_r_q} * {5'd0, sph_r_q} : {5'd0, ea} * {5'd0, ea};
			b2_q   <= {5'd0, eb} * {5'd0, eb};
			c2_q   <= {5'd0, ec} * {5'd0, ec};
		end
		if (cmd.setup_b) begin
			cp_q <= is_sph ? 20'd1 : {10'd0, b2_q} * {10'd0, c2_q};
			cq_q <= is_sph ? 20'd1 : {10'd0, a2_q} * {10'd0, c2_q};
			cs_q <= is_sph ? 20'd1 : {10'd0, a2_q} * {10'd0, b2_q};
		end
		if (cmd.setup_c) begin
			lim_q <= is_sph ? {22'd0, a2_q} : {12'd0, cs_q} * {22'd0, c2_q};
		end
	end

	// scan counters, column innermost, plane outermost
	logic [6:0] oi_q, oj_q, ok_q;
	logic       end_i, end_j, end_k;
	assign end_i = (oi_q == hi_i_q);
	assign end_j = (oj_q == hi_j_q);
	assign end_k = (ok_q == hi_k_q);
	assign stat.scan_last = end_i && end_j && end_k;

	always_ff @(posedge clk) begin
		if (cmd.setup_b) begin
			oi_q <= lo_i_q;
			oj_q <= lo_j_q;
			ok_q <= lo_k_q;
		end else if (cmd.scan_en) begin
			if (!end_j) begin
				oj_q <= oj_q + 7'd1;
			end else begin
				oj_q <= lo_j_q;
				if (!end_i) begin
					oi_q <= oi_q + 7'd1;
				end else begin
					oi_q <= lo_i_q;
					ok_q <= ok_q + 7'd1;
				end
			end
		end
	end

	// test pipeline: squares, weighted terms, compare and write
	logic        v_s1, v_s2;
	logic [8:0]  row_s1, col_s1, pln_s1;
	logic [11:0] sqi_s1, sqj_s1, sqk_s1;
	logic        in_s2;
	logic [AW-1:0] addr_s2;
	logic [31:0] ti_s2, tj_s2, tk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= 9'($signed({4'b0, ar_q}) + $signed({{2{oi_q[6]}}, oi_q}));
		col_s1 <= 9'($signed({4'b0, ac_q}) + $signed({{2{oj_q[6]}}, oj_q}));
		pln_s1 <= 9'($signed({4'b0, ap_q}) + $signed({{2{ok_q[6]}}, ok_q}));
		sqi_s1 <= $signed({{5{oi_q[6]}}, oi_q}) * $signed({{5{oi_q[6]}}, oi_q});
		sqj_s1 <= $signed({{5{oj_q[6]}}, oj_q}) * $signed({{5{oj_q[6]}}, oj_q});
		sqk_s1 <= $signed({{5{ok_q[6]}}, ok_q}) * $signed({{5{ok_q[6]}}, ok_q});

		in_s2 <= !row_s1[8] && !col_s1[8] && !pln_s1[8] &&
		         ({1'b0, row_s1[7:0]} < ROWS_L) &&
		         ({1'b0, col_s1[7:0]} < COLS_L) &&
		         ({1'b0, pln_s1[7:0]} < PLANES_L);
		addr_s2 <= AW'((32'(pln_s1[7:0]) * GRID_ROWS + 32'(row_s1[7:0])) * GRID_COLS +
		               32'(col_s1[7:0]));
		ti_s2 <= {20'd0, sqi_s1} * {12'd0, cp_q};
		tj_s2 <= {20'd0, sqj_s1} * {12'd0, cq_q};
		tk_s2 <= {20'd0, sqk_s1} * {12'd0, cs_q};
	end

	logic hit;
	assign hit = v_s2 && in_s2 && (!test_q || (ti_s2 + tj_s2 + tk_s2 <= lim_q));
	assign stat.pipe_busy = v_s1 || v_s2;

	logic [15:0] touched_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
		end else if (cmd.capture) begin
			touched_q <= '0;
		end else if (hit) begin
			touched_q <= touched_q + 16'd1;
		end
	end

	// clearing pass
	logic [AW-1:0] clr_q;
	assign stat.clr_last = (clr_q == LAST_ADDR);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// grid memory: flags and colors kept apart so a cut leaves the color
	logic          on_mem  [DEPTH];
	logic [31:0]   col_mem [DEPTH];
	logic          anc_in;
	logic [AW-1:0] anc_addr;
	logic          rd_on_q;
	logic [31:0]   rd_col_q;

	assign anc_in = ({4'b0, ar_q} < ROWS_L) && ({4'b0, ac_q} < COLS_L) &&
	                ({4'b0, ap_q} < PLANES_L);
	assign anc_addr = AW'((32'(ap_q) * GRID_ROWS + 32'(ar_q)) * GRID_COLS + 32'(ac_q));

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			on_mem[clr_q]  <= 1'b0;
			col_mem[clr_q] <= '0;
		end else if (hit) begin
			on_mem[addr_s2] <= put;
			if (put) col_mem[addr_s2] <= color_q;
		end
		if (cmd.read_en) begin
			rd_on_q  <= on_mem[anc_addr];
			rd_col_q <= col_mem[anc_addr];
		end
	end

	// result register
	logic        ov_q;
	logic [55:0] od_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			od_q <= {7'd0, touched_q, anc_in ? rd_col_q : 32'd0, anc_in & rd_on_q};
		end
	end

	assign stat.out_full = ov_q && !out_ready;
	assign out_valid     = ov_q;
	assign out_data      = od_q;

endmodule

// ----- rtl/voxel_shape_rasterizer.sv -----
// Top level of the voxel shape rasterizer.
//
//  channel  | signals                       | payload
//  ---------+-------------------------------+------------------------------------
//  in       | s_tvalid s_tready s_tdata/user| tuser: kind; tdata: row, col, plane
//  out      | m_tvalid m_tready m_tdata     | voxel_on, voxel_color, cells_touched
//  config   | cfg_we cfg_addr cfg_data      | one register per write
//
// After reset the grid is swept clear, all GRID_ROWS*GRID_COLS*GRID_PLANES cells, with
// s_tready low. A command then visits each candidate cell of its shape's bounding range
// in turn (up to 63^3 cells for the widest ellipsoid or box), one at a time through the
// single write port of the grid memory. A read or an empty shape skips the scan.
// A result waits in the output register; a new item is taken meanwhile, and its
// own result waits for m_tready.
module voxel_shape_rasterizer #(
	parameter int GRID_ROWS   = 32,
	parameter int GRID_COLS   = 32,
	parameter int GRID_PLANES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // anchor_row[4:0], anchor_col[9:5], anchor_plane[14:10]
	input  logic [3:0]  s_tuser,  // kind[3:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata   // voxel_on[0], voxel_color[32:1], cells_touched[48:33]
);

	vsr_pkg::vsr_cmd_t  cmd;
	vsr_pkg::vsr_stat_t stat;

	vsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	vsr_dp #(
		.GRID_ROWS   (GRID_ROWS),
		.GRID_COLS   (GRID_COLS),
		.GRID_PLANES (GRID_PLANES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_kind   (s_tuser),
		.in_row    (s_tdata[4:0]),
		.in_col    (s_tdata[9:5]),
		.in_plane  (s_tdata[14:10]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ----- sim/voxel_grid_checker.sv -----
// Checker for the voxel shape rasterizer: grid prediction and result comparison.
`timescale 1ns / 100ps
module voxel_grid_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,  // anchor_row[4:0], anchor_col[9:5], anchor_plane[14:10]
	input  logic [3:0]  s_tuser,  // kind[3:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // voxel_on[0], voxel_color[32:1], cells_touched[48:33]
	output int          errors,
	output int          pending
);

	localparam int N = 32;

	// lowest field last, to line up with m_tdata
	typedef struct packed {
		logic [15:0] touched;
		logic [31:0] color;
		logic        on;
	} anchor_state_t;

	bit          grid_on [N*N*N];
	logic [31:0] grid_color [N*N*N];
	logic [5:0]  box_r, box_c, box_p;
	logic [4:0]  sph_r, ell_a, ell_b, ell_c;
	logic [31:0] paint_color;
	int          touched;
	anchor_state_t expected_results[$];

	assign pending = expected_results.size();

	function automatic longint sq(int v);
		return longint'(v) * longint'(v);
	endfunction

	task automatic write_cell(int r, int c, int p, bit put);
		int ix;
		if (r < 0 || r >= N || c < 0 || c >= N || p < 0 || p >= N)
			return;
		ix = (p * N + r) * N + c;
		grid_on[ix] = put;
		if (put)
			grid_color[ix] = paint_color;
		touched++;
	endtask

	task automatic apply_command(logic [3:0] kind, int r0, int c0, int p0);
		bit put;
		int rr, a, b, c, ix;
		longint a2, b2, c2;
		anchor_state_t res;
		put = !kind[0];
		touched = 0;
		case (kind)
			vsr_pkg::KIND_PUT_VOXEL, vsr_pkg::KIND_CUT_VOXEL: write_cell(r0, c0, p0, put);
			vsr_pkg::KIND_PUT_BOX, vsr_pkg::KIND_CUT_BOX: begin
				for (int k = 0; k < box_p; k++)
					for (int i = 0; i < box_r; i++)
						for (int j = 0; j < box_c; j++)
							write_cell(r0 + i, c0 + j, p0 + k, put);
			end
			vsr_pkg::KIND_PUT_SPHERE, vsr_pkg::KIND_CUT_SPHERE: begin
				rr = sph_r;
				for (int k = -rr; k <= rr; k++)
					for (int i = -rr; i <= rr; i++)
						for (int j = -rr; j <= rr; j++)
							if (sq(i) + sq(j) + sq(k) <= sq(rr))
								write_cell(r0 + i, c0 + j, p0 + k, put);
			end
			vsr_pkg::KIND_PUT_ELLIPSOID, vsr_pkg::KIND_CUT_ELLIPSOID: begin
				a = ell_a;
				b = ell_b;
				c = ell_c;
				// a flat axis loops over one slice; weight it 1 so the other two form the ellipse
				a2 = a ? sq(a) : 1;
				b2 = b ? sq(b) : 1;
				c2 = c ? sq(c) : 1;
				if ((a == 0) + (b == 0) + (c == 0) < 2)
					for (int k = -c; k <= c; k++)
						for (int i = -a; i <= a; i++)
							for (int j = -b; j <= b; j++)
								if (sq(i)*b2*c2 + sq(j)*a2*c2 + sq(k)*a2*b2 <= a2*b2*c2)
									write_cell(r0 + i, c0 + j, p0 + k, put);
			end
			default: ;
		endcase
		ix = (p0 * N + r0) * N + c0;
		res.on = grid_on[ix];
		res.color = grid_color[ix];
		res.touched = touched[15:0];
		expected_results.insert(expected_results.size(), res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		anchor_state_t got, exp_res;
		if (!arst_n) begin
			foreach (grid_on[i]) begin
				grid_on[i] = 0;
				grid_color[i] = '0;
			end
			{box_r, box_c, box_p} = '0;
			{sph_r, ell_a, ell_b, ell_c} = '0;
			paint_color = vsr_pkg::DRAW_COLOR_RST;
			expected_results.delete();
			errors = 0;
		end else begin
			// compare before predicting: a result never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				got = m_tdata[48:0];
				if (expected_results.size() == 0) begin
					$error("result with no command pending");
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					if (got.on !== exp_res.on) begin
						$error("voxel_on: expected %0d, got %0d", exp_res.on, got.on);
						errors++;
					end
					if (got.color !== exp_res.color) begin
						$error("voxel_color: expected %h, got %h", exp_res.color, got.color);
						errors++;
					end
					if (got.touched !== exp_res.touched) begin
						$error("cells_touched: expected %0d, got %0d",
							exp_res.touched, got.touched);
						errors++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_addr)
					vsr_pkg::CFG_BOX_ROWS:    box_r = cfg_data[5:0];
					vsr_pkg::CFG_BOX_COLS:    box_c = cfg_data[5:0];
					vsr_pkg::CFG_BOX_PLANES:  box_p = cfg_data[5:0];
					vsr_pkg::CFG_SPHERE_R:    sph_r = cfg_data[4:0];
					vsr_pkg::CFG_ELL_ROW_R:   ell_a = cfg_data[4:0];
					vsr_pkg::CFG_ELL_COL_R:   ell_b = cfg_data[4:0];
					vsr_pkg::CFG_ELL_PLANE_R: ell_c = cfg_data[4:0];
					vsr_pkg::CFG_DRAW_COLOR:  paint_color = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[14:10]);
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the voxel shape rasterizer: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb;

	localparam logic [3:0] KIND_READ     = 4'd8;
	localparam logic [3:0] KIND_SPARE_LO = 4'd9;
	localparam logic [3:0] KIND_SPARE_HI = 4'd15;
	localparam int STALL_LIMIT = 1500000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_addr = '0;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [3:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [55:0] m_tdata;
	int          errors, pending;
	int          send_idle = 0, recv_idle = 0;
	int          hold_req = 0, hold_seen = 0, hold_left = 0;
	int          quiet_cycles = 0;

	always #5 clk = ~clk;

	voxel_shape_rasterizer i_dut (.*);

	voxel_grid_checker i_checker (.*);

	// receiver: random backpressure, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			m_tready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_cmd(logic [3:0] kind, int r, int c, int p);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {1'b0, 5'(p), 5'(c), 5'(r)};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(int count);
		logic [3:0] kind;
		repeat (count) begin
			kind = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
			send_cmd(kind, $urandom, $urandom, $urandom);
		end
	endtask

	// drop valid and let the block finish before touching registers
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		#1;
		wait (pending == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_reg(logic [2:0] addr, logic [31:0] value);
		cfg_we <= 1;
		cfg_addr <= addr;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_shapes(int br, int bc, int bp, int sr, int ea, int eb, int ec);
		set_reg(vsr_pkg::CFG_BOX_ROWS, br);
		set_reg(vsr_pkg::CFG_BOX_COLS, bc);
		set_reg(vsr_pkg::CFG_BOX_PLANES, bp);
		set_reg(vsr_pkg::CFG_SPHERE_R, sr);
		set_reg(vsr_pkg::CFG_ELL_ROW_R, ea);
		set_reg(vsr_pkg::CFG_ELL_COL_R, eb);
		set_reg(vsr_pkg::CFG_ELL_PLANE_R, ec);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic random_phase(int s_idle, int r_idle, int count);
		drain();
		send_idle = s_idle;
		recv_idle = r_idle;
		set_reg(vsr_pkg::CFG_DRAW_COLOR, $urandom);
		set_shapes($urandom_range(4), $urandom_range(4), $urandom_range(4),
			$urandom_range(3), $urandom_range(3), $urandom_range(3), $urandom_range(3));
		send_random(count);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;

		// directed: reset defaults, grid corners, every kind
		send_cmd(KIND_READ, 0, 0, 0);
		send_cmd(vsr_pkg::KIND_PUT_VOXEL, 0, 0, 0);
		send_cmd(vsr_pkg::KIND_PUT_VOXEL, 31, 31, 31);
		send_cmd(vsr_pkg::KIND_CUT_VOXEL, 0, 0, 0);
		send_cmd(vsr_pkg::KIND_PUT_BOX, 5, 5, 5);
		send_cmd(vsr_pkg::KIND_PUT_SPHERE, 5, 5, 5);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 5, 5, 5);
		drain();
		set_reg(vsr_pkg::CFG_DRAW_COLOR, 32'hffff_ffff);
		set_shapes(2, 3, 4, 2, 3, 2, 1);
		send_cmd(vsr_pkg::KIND_PUT_BOX, 30, 29, 31);
		send_cmd(vsr_pkg::KIND_CUT_BOX, 31, 31, 31);
		send_cmd(vsr_pkg::KIND_PUT_SPHERE, 0, 31, 0);
		send_cmd(vsr_pkg::KIND_CUT_SPHERE, 1, 30, 0);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 31, 0, 31);
		send_cmd(vsr_pkg::KIND_CUT_ELLIPSOID, 30, 1, 31);
		send_cmd(KIND_SPARE_LO, 31, 0, 31);
		send_cmd(KIND_SPARE_HI, 0, 31, 0);
		drain();
		set_reg(vsr_pkg::CFG_DRAW_COLOR, 32'h0);
		set_shapes(0, 5, 5, 0, 0, 3, 2);
		send_cmd(vsr_pkg::KIND_PUT_BOX, 10, 10, 10);
		send_cmd(vsr_pkg::KIND_PUT_SPHERE, 31, 31, 31);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 10, 10, 10);
		drain();
		set_shapes(1, 0, 1, 1, 3, 0, 2);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 12, 12, 0);
		drain();
		set_shapes(1, 1, 0, 1, 0, 0, 4);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 12, 12, 12);
		drain();
		set_reg(vsr_pkg::CFG_DRAW_COLOR, 32'h1234_5678);
		set_shapes(32, 32, 32, 31, 31, 31, 31);
		send_cmd(vsr_pkg::KIND_PUT_BOX, 0, 0, 0);
		send_cmd(vsr_pkg::KIND_CUT_SPHERE, 16, 16, 16);
		send_cmd(vsr_pkg::KIND_PUT_ELLIPSOID, 15, 16, 17);

		random_phase(20, 77, 25);
		// fill the block while the receiver holds off
		hold_req++;
		send_random(10);
		random_phase(77, 20, 25);
		random_phase(0, 0, 25);

		drain();
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/vsr_pkg.sv
rtl/vsr_ctrl.sv
rtl/vsr_dp.sv
rtl/voxel_shape_rasterizer.sv
sim/voxel_grid_checker.sv
sim/tb.sv
